[sv/fegx_pkg.sv]
// Package for the frame encoder with group XOR check bytes.
// Holds framing constants, register indexes and the check shaping function.
// No dependencies.
package fegx_pkg;

    // Payload limit default and the fixed group size.
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int GROUP_SIZE      = 8;
    localparam int GROUP_SHIFT     = $clog2(GROUP_SIZE);

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 1;
    localparam int CFG_AW = 2;

    // Framing bytes.
    localparam logic [BYTE_W-1:0] START_BYTE     = 8'h0D;
    localparam logic [BYTE_W-1:0] ALT_START_BYTE = 8'h20;
    localparam logic [BYTE_W-1:0] END_BYTE       = 8'h0A;
    localparam logic [BYTE_W-1:0] CHECK_OFFSET   = 8'd64;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_PARITY_ENABLE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_CORRUPT_START = 2'd1;
    localparam logic [CFG_AW-1:0] REG_DROP_END      = 2'd2;

    // A check outside 64..127 gets the offset added, modulo 256.
    function automatic logic [BYTE_W-1:0] shape_check(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        if (v[7:6] != 2'b01) begin
            r = v + CHECK_OFFSET;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/fegx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the stored group checks; no package dependency.
module fegx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/frame_encoder_group_xor_check_unit.sv]
// Frame encoder: start byte, payload, per-group XOR checks, end byte.
// ST_START sends the start byte ahead of a frame's first byte and ST_DATA sends each taken
// byte; a dropped byte is not sent. After the last byte, ST_CHECK_RD reads each check from
// RAM and ST_CHECK sends it, then ST_END the end byte. Input is taken only in ST_IDLE.
// Reset (aresetn, synchronous, low) clears counters, flags and the sequencer; the
// check RAM is not cleared since only entries written in the current frame are read.
module frame_encoder_group_xor_check_unit #(
    parameter int MAX_PAYLOAD = fegx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_we,
    input  logic [fegx_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [fegx_pkg::CFG_W-1:0]     cfg_wdata,
    // Input channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fegx_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_is_last,
    // Result channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fegx_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                           m_frame_end,
    output logic                           m_overflow
);

    localparam int BW         = fegx_pkg::BYTE_W;
    localparam int GS         = fegx_pkg::GROUP_SIZE;
    localparam int GSH        = fegx_pkg::GROUP_SHIFT;
    localparam int NUM_GROUPS = (MAX_PAYLOAD + GS - 1) / GS;
    localparam int CNT_W      = $clog2(MAX_PAYLOAD + 1);
    localparam int GRP_W      = $clog2(NUM_GROUPS + 1);
    localparam int ADDR_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_START    = 3'd1;
    localparam logic [2:0] ST_DATA     = 3'd2;
    localparam logic [2:0] ST_CHECK_RD = 3'd3;
    localparam logic [2:0] ST_CHECK    = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

    // Configuration registers.
    logic parity_enable_reg;
    logic corrupt_start_reg;
    logic drop_end_reg;

    // Message state.
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [BW-1:0]    group_xor_reg, group_xor_next;
    logic             overflowed_reg, overflowed_next;

    // Latched transaction context.
    logic [2:0]       state_reg, state_next;
    logic [BW-1:0]    data_reg;
    logic [BW-1:0]    start_reg;
    logic             last_reg;
    logic             drop_reg;
    logic             ov_reg;
    logic [GRP_W-1:0] grp_cnt_reg, grp_cnt_next;

    // Output register.
    logic             m_valid_reg;
    logic [BW-1:0]    out_byte_reg;
    logic             frame_end_reg;
    logic             overflow_reg;

    // Datapath signals.
    logic             accept;
    logic             first_byte;
    logic             take_byte;
    logic [BW-1:0]    xor_new;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W:0]   cnt_round;
    logic [GRP_W-1:0] groups_new;
    logic             group_full;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BW-1:0]    ram_rdata;
    logic             out_free;
    logic             out_load;
    logic [BW-1:0]    out_byte_next;
    logic             frame_end_next;

    // Where the sequence goes after the payload byte.
    function automatic logic [2:0] after_data(input logic last, input logic [GRP_W-1:0] grp,
                                              input logic drop);
        logic [2:0] s;
        if (!last) begin
            s = ST_IDLE;
        end else if (grp != '0) begin
            s = ST_CHECK_RD;
        end else if (!drop) begin
            s = ST_END;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_enable_reg <= 1'b1;
            corrupt_start_reg <= 1'b0;
            drop_end_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                fegx_pkg::REG_PARITY_ENABLE: parity_enable_reg <= cfg_wdata[0];
                fegx_pkg::REG_CORRUPT_START: corrupt_start_reg <= cfg_wdata[0];
                fegx_pkg::REG_DROP_END:      drop_end_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Per-byte update of the count, the running XOR and the group store.
    always_comb begin
        first_byte      = (byte_count_reg == '0) && !overflowed_reg;
        take_byte       = (byte_count_reg < MAX_CNT);
        xor_new         = take_byte ? (group_xor_reg ^ s_data_byte) : group_xor_reg;
        byte_count_next = take_byte ? (byte_count_reg + CNT_W'(1)) : byte_count_reg;
        overflowed_next = overflowed_reg || !take_byte;
        group_full      = (byte_count_next[GSH-1:0] == '0);
        cnt_m1          = byte_count_next - CNT_W'(1);
        cnt_round       = {1'b0, byte_count_next} + (CNT_W+1)'(GS - 1);
        groups_new      = parity_enable_reg ? GRP_W'(cnt_round >> GSH) : '0;
        ram_we          = accept && ((take_byte && group_full) || (s_is_last && !group_full));
        ram_waddr       = ADDR_W'(cnt_m1 >> GSH);
        group_xor_next  = (group_full || s_is_last) ? '0 : xor_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            group_xor_reg  <= '0;
            overflowed_reg <= 1'b0;
        end else if (accept) begin
            byte_count_reg <= s_is_last ? '0 : byte_count_next;
            group_xor_reg  <= group_xor_next;
            overflowed_reg <= s_is_last ? 1'b0 : overflowed_next;
        end
    end

    // Latch the transaction context at acceptance.
    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg  <= s_data_byte;
            start_reg <= corrupt_start_reg ? fegx_pkg::ALT_START_BYTE : fegx_pkg::START_BYTE;
            last_reg  <= s_is_last;
            drop_reg  <= drop_end_reg;
            ov_reg    <= overflowed_next;
        end
    end

    fegx_ram #(
        .WIDTH (BW),
        .DEPTH (NUM_GROUPS),
        .AW    (ADDR_W)
    ) u_check_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (xor_new),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign ram_raddr = ADDR_W'(grp_cnt_reg - GRP_W'(1));

    // Sequencer: each output state loads one result into the output register.
    always_comb begin
        state_next     = state_reg;
        grp_cnt_next   = grp_cnt_reg;
        out_load       = 1'b0;
        out_byte_next  = data_reg;
        frame_end_next = 1'b0;
        ram_re         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    grp_cnt_next = s_is_last ? groups_new : '0;
                    if (first_byte) begin
                        state_next = ST_START;
                    end else if (take_byte) begin
                        state_next = ST_DATA;
                    end else begin
                        state_next = after_data(s_is_last, s_is_last ? groups_new : '0,
                                                drop_end_reg);
                    end
                end
            end
            ST_START: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_byte_next = start_reg;
                    state_next    = ST_DATA;
                end
            end
            ST_DATA: begin
                // The start byte may precede an overflowed byte only if none was taken,
                // which cannot happen, so ST_DATA always carries a taken byte.
                if (out_free) begin
                    out_load       = 1'b1;
                    out_byte_next  = data_reg;
                    frame_end_next = last_reg && (grp_cnt_reg == '0) && drop_reg;
                    state_next     = after_data(last_reg, grp_cnt_reg, drop_reg);
                end
            end
            ST_CHECK_RD: begin
                ram_re     = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_byte_next  = fegx_pkg::shape_check(ram_rdata);
                    frame_end_next = (grp_cnt_reg == GRP_W'(1)) && drop_reg;
                    grp_cnt_next   = grp_cnt_reg - GRP_W'(1);
                    if (grp_cnt_reg > GRP_W'(1)) begin
                        state_next = ST_CHECK_RD;
                    end else if (!drop_reg) begin
                        state_next = ST_END;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_byte_next  = fegx_pkg::END_BYTE;
                    frame_end_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            grp_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            grp_cnt_reg <= grp_cnt_next;
        end
    end

    // Output register; the start byte never carries the overflow flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= frame_end_next;
            overflow_reg  <= (state_reg == ST_START) ? 1'b0 : ov_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_frame_end = frame_end_reg;
    assign m_overflow  = overflow_reg;

    // The overflow flag is only set once the payload limit is reached.
    a_ovf_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        overflowed_reg |-> (byte_count_reg == MAX_CNT))
        else $error("overflow flag set below the payload limit");

    // The byte count never passes the payload limit.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= MAX_CNT)
        else $error("byte count beyond the payload limit");

    // Check states always have a stored group left to send.
    a_check_grp: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_CHECK_RD) || (state_reg == ST_CHECK)) |->
        ((grp_cnt_reg != '0) && (grp_cnt_reg <= GRP_W'(NUM_GROUPS))))
        else $error("check state without a pending group");

    // The check state is entered only from its RAM read state in the previous cycle.
    a_read_before_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) && !$past(state_reg == ST_CHECK) |->
        $past(state_reg == ST_CHECK_RD))
        else $error("check state entered without a RAM read");

endmodule

[tb/frame_line_checker.sv]
// Checker for the frame encoder: tracks register writes and predicts the framed line bytes.
// Compares every accepted result against the prediction and counts mismatches.
// Depends on fegx_pkg for framing bytes, group size and register indexes.
module frame_line_checker #(
    parameter int MAX_PAYLOAD = fegx_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [fegx_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [fegx_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [fegx_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                           s_is_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [fegx_pkg::BYTE_W-1:0]    m_out_byte,
    input  logic                           m_frame_end,
    input  logic                           m_overflow,
    output int unsigned                    mismatches,
    output int unsigned                    outstanding,
    output int unsigned                    line_bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W     = fegx_pkg::BYTE_W;
    localparam int GROUP_SIZE = fegx_pkg::GROUP_SIZE;
    localparam int NUM_GROUPS = (MAX_PAYLOAD + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic              frame_end;
        logic              overflow;
    } line_byte_t;

    // Line bytes that the encoder still owes, oldest first.
    line_byte_t        expected_line[$];
    line_byte_t        want;

    // Shadow of the register file and of the framing state.
    logic              par_en;
    logic              alt_start;
    logic              no_end;
    int unsigned       payload_count;
    logic [BYTE_W-1:0] run_xor;
    logic [BYTE_W-1:0] group_xor_mem [NUM_GROUPS];
    logic              dropped;
    int unsigned       fail_tally;
    int unsigned       check_tally;

    // Checks outside 64..127 are pushed up by the offset, wrapping at 256.
    function automatic logic [BYTE_W-1:0] offset_check(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] shaped;
        if (raw < fegx_pkg::CHECK_OFFSET || raw >= 8'd128) begin
            shaped = raw + fegx_pkg::CHECK_OFFSET;
        end else begin
            shaped = raw;
        end
        return shaped;
    endfunction

    task automatic push_line(input logic [BYTE_W-1:0] b, input logic fe, input logic ov);
        expected_line.push_back(line_byte_t'{line_byte: b, frame_end: fe, overflow: ov});
    endtask

    // Works out every line byte that one payload transaction produces.
    task automatic encode_payload(input logic [BYTE_W-1:0] d, input logic last);
        int unsigned n_groups;
        int unsigned g;
        logic        took;
        took     = 1'b0;
        n_groups = 0;
        if (payload_count == 0 && !dropped) begin
            push_line(alt_start ? fegx_pkg::ALT_START_BYTE : fegx_pkg::START_BYTE,
                      1'b0, 1'b0);
        end
        if (payload_count < MAX_PAYLOAD) begin
            took          = 1'b1;
            run_xor       = run_xor ^ d;
            payload_count = payload_count + 1;
            if (payload_count % GROUP_SIZE == 0) begin
                group_xor_mem[(payload_count - 1) / GROUP_SIZE] = run_xor;
                run_xor = '0;
            end
        end else begin
            dropped = 1'b1;
        end
        if (!last) begin
            if (took) begin
                push_line(d, 1'b0, dropped);
            end
        end else begin
            // A partial final group still gets its own check.
            if (payload_count % GROUP_SIZE != 0) begin
                group_xor_mem[payload_count / GROUP_SIZE] = run_xor;
            end
            if (par_en) begin
                n_groups = (payload_count + GROUP_SIZE - 1) / GROUP_SIZE;
            end
            if (n_groups > NUM_GROUPS) begin
                n_groups = NUM_GROUPS;
            end
            if (took) begin
                push_line(d, (n_groups == 0) && no_end, dropped);
            end
            for (g = n_groups; g > 0; g--) begin
                push_line(offset_check(group_xor_mem[g - 1]), (g == 1) && no_end, dropped);
            end
            if (!no_end) begin
                push_line(fegx_pkg::END_BYTE, 1'b1, dropped);
            end
            payload_count = 0;
            run_xor       = '0;
            dropped       = 1'b0;
        end
    endtask

    // Register writes, result comparison and prediction, all sampled at the clock edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            par_en        = 1'b1;
            alt_start     = 1'b0;
            no_end        = 1'b0;
            payload_count = 0;
            run_xor       = '0;
            dropped       = 1'b0;
            fail_tally    = 0;
            check_tally   = 0;
            expected_line.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    fegx_pkg::REG_PARITY_ENABLE: par_en = cfg_wdata[0];
                    fegx_pkg::REG_CORRUPT_START: alt_start = cfg_wdata[0];
                    fegx_pkg::REG_DROP_END:      no_end = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                check_tally = check_tally + 1;
                if (expected_line.size() == 0) begin
                    $error("unexpected line byte %0h with no transaction pending", m_out_byte);
                    fail_tally = fail_tally + 1;
                end else begin
                    want = expected_line.pop_front();
                    if (m_out_byte !== want.line_byte) begin
                        $error("out_byte: expected %0h, actual %0h", want.line_byte, m_out_byte);
                        fail_tally = fail_tally + 1;
                    end
                    if (m_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b", want.frame_end,
                               m_frame_end);
                        fail_tally = fail_tally + 1;
                    end
                    if (m_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, m_overflow);
                        fail_tally = fail_tally + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                encode_payload(s_data_byte, s_is_last);
            end
        end
        mismatches         <= fail_tally;
        outstanding        <= expected_line.size();
        line_bytes_checked <= check_tally;
    end

endmodule

[tb/tb_frame_encoder_group_xor_check_unit.sv]
// Top of the frame encoder testbench: clock, reset, payload and register stimulus.
// Instantiates the encoder and frame_line_checker, which predicts and compares.
// Depends on fegx_pkg and frame_encoder_group_xor_check_unit.
module tb_frame_encoder_group_xor_check_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BYTE_W        = fegx_pkg::BYTE_W;
    localparam int          PAYLOAD_LIMIT = fegx_pkg::MAX_PAYLOAD_DEF;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_we;
    logic [fegx_pkg::CFG_AW-1:0] cfg_addr;
    logic [fegx_pkg::CFG_W-1:0]  cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic [BYTE_W-1:0]           s_data_byte;
    logic                        s_is_last;
    logic                        m_valid;
    logic                        m_ready;
    logic [BYTE_W-1:0]           m_out_byte;
    logic                        m_frame_end;
    logic                        m_overflow;

    int unsigned         mismatches;
    int unsigned         outstanding;
    int unsigned         line_bytes_checked;
    int unsigned         payload_sent;
    int unsigned         frames_sent;
    int unsigned         settings_used;
    logic [BYTE_W-1:0]   frame_bytes[$];

    frame_encoder_group_xor_check_unit #(
        .MAX_PAYLOAD (PAYLOAD_LIMIT)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_is_last   (s_is_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_overflow  (m_overflow)
    );

    frame_line_checker #(
        .MAX_PAYLOAD (PAYLOAD_LIMIT)
    ) u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_is_last          (s_is_last),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_byte         (m_out_byte),
        .m_frame_end        (m_frame_end),
        .m_overflow         (m_overflow),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .line_bytes_checked (line_bytes_checked)
    );

    // 2 ns clock.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the encoder hangs.
    initial begin
        #1_500_000;
        $display("frame_encoder_group_xor_check_unit verification failed");
        $finish;
    end

    // Idle spans: mostly none or short, now and then long.
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Payload values lean toward the ones that shape checks at their edges.
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] corner [7];
        corner = '{8'h00, 8'hFF, 8'hC0, 8'h7F, 8'h80, 8'h3F, 8'h40};
        if ($urandom_range(0, 9) == 0) begin
            return corner[$urandom_range(0, 6)];
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Message lengths: mostly within two groups, some spanning several.
    function automatic int unsigned message_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 12);
        end else if (r < 97) begin
            return $urandom_range(13, 24);
        end
        return $urandom_range(25, 40);
    endfunction

    // Offers one payload transaction and holds it until the encoder takes it.
    task automatic offer_payload(input logic [BYTE_W-1:0] d, input logic last,
                                 input int unsigned gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_is_last   <= last;
        do @(posedge aclk); while (!s_ready);
        payload_sent++;
    endtask

    // Sends the bytes in frame_bytes as one message, marking the final one.
    task automatic send_frame(input bit burst);
        int unsigned i;
        for (i = 0; i < frame_bytes.size(); i++) begin
            offer_payload(frame_bytes[i], i == frame_bytes.size() - 1,
                          burst ? 0 : idle_span());
        end
        frames_sent++;
    endtask

    task automatic fill_random_frame(input int unsigned len);
        frame_bytes.delete();
        repeat (len) frame_bytes.push_back(pick_byte());
    endtask

    // Stops offering and waits until every predicted line byte has come out.
    task automatic drain_and_settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all three registers on consecutive cycles.
    task automatic write_settings(input logic pe, input logic cs, input logic de);
        cfg_we    <= 1'b1;
        cfg_addr  <= fegx_pkg::REG_PARITY_ENABLE;
        cfg_wdata <= pe;
        @(posedge aclk);
        cfg_addr  <= fegx_pkg::REG_CORRUPT_START;
        cfg_wdata <= cs;
        @(posedge aclk);
        cfg_addr  <= fegx_pkg::REG_DROP_END;
        cfg_wdata <= de;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Result side: random ready pattern, with a long hold-off every few hundred bytes.
    // The first hold-off lands inside the oversized message, while payload keeps coming.
    initial begin
        int unsigned lines_taken;
        int unsigned hold_at;
        int unsigned gap;
        lines_taken = 0;
        hold_at     = 200;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = idle_span();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) begin
                @(posedge aclk);
                if (m_valid) begin
                    lines_taken++;
                end
            end
            if (lines_taken >= hold_at) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_at = lines_taken + 400;
            end
        end
    end

    // Payload and register stimulus, then the verdict.
    initial begin
        int unsigned phase;
        logic [2:0]  combo;
        payload_sent  = 0;
        frames_sent   = 0;
        settings_used = 0;
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_addr    <= fegx_pkg::REG_PARITY_ENABLE;
        cfg_wdata   <= '0;
        s_valid     <= 1'b0;
        s_data_byte <= '0;
        s_is_last   <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames under the reset settings: a check that wraps to zero,
        // field extremes across two groups, and a check left as it is.
        frame_bytes = '{8'hC0};
        send_frame(1'b1);
        frame_bytes = '{8'h00, 8'hFF, 8'h40, 8'h3F, 8'h7F, 8'h80, 8'h01, 8'h55, 8'hAA};
        send_frame(1'b0);
        frame_bytes = '{8'h41};
        send_frame(1'b1);

        // No checks, alternate start byte, no end byte: the last payload byte ends the frame.
        drain_and_settle();
        write_settings(1'b0, 1'b1, 1'b1);
        frame_bytes = '{8'h12, 8'h34};
        send_frame(1'b1);

        // Checks without an end byte: the group 0 check ends the frame.
        drain_and_settle();
        write_settings(1'b1, 1'b0, 1'b1);
        frame_bytes = '{8'h99};
        send_frame(1'b0);
        frame_bytes = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
        send_frame(1'b1);

        drain_and_settle();
        write_settings(1'b0, 1'b0, 1'b0);
        frame_bytes = '{8'h7E};
        send_frame(1'b0);

        // Random messages, one under each register combination.
        for (phase = 0; phase < 8; phase++) begin
            combo = phase[2:0];
            drain_and_settle();
            write_settings(combo[0], combo[1], combo[2]);
            fill_random_frame(message_length());
            send_frame($urandom_range(0, 3) == 0);
        end

        // Oversized message: dropped bytes, the dropped last byte, all 32 checks flagged,
        // then a short one to confirm the framing state came back clean.
        drain_and_settle();
        write_settings(1'b1, 1'($urandom_range(0, 1)), 1'b0);
        fill_random_frame(PAYLOAD_LIMIT + 2);
        send_frame($urandom_range(0, 1) == 0);
        fill_random_frame(3);
        send_frame(1'b0);

        drain_and_settle();
        repeat (16) @(posedge aclk);
        $display("Sent %0d payload transactions in %0d messages under %0d register settings.",
                 payload_sent, frames_sent, settings_used);
        $display("Compared %0d line bytes, including an oversized frame with flagged checks.",
                 line_bytes_checked);
        if (mismatches == 0) begin
            $display("frame_encoder_group_xor_check_unit verification clean");
        end else begin
            $display("frame_encoder_group_xor_check_unit verification failed");
        end
        $finish;
    end

endmodule

[frame_encoder_group_xor_check_unit.f]
sv/fegx_pkg.sv
sv/fegx_ram.sv
sv/frame_encoder_group_xor_check_unit.sv
tb/frame_line_checker.sv
tb/tb_frame_encoder_group_xor_check_unit.sv
